// File: design/gcr_pkg.sv
// ----------------------------------------------------------------------------
// gcr_pkg
// Shared types, codes and tables of the six-and-two GCR sector encoder.
// ----------------------------------------------------------------------------
package gcr_pkg;

    localparam int SECTOR_BYTES = 256;
    localparam int AUX_NIBBLES  = 86;
    localparam int STORE_AW     = $clog2(SECTOR_BYTES);
    localparam int POS_W        = 9;

    localparam logic [POS_W-1:0] AUX_OFS1 = POS_W'(AUX_NIBBLES);
    localparam logic [POS_W-1:0] AUX_OFS2 = POS_W'(2 * AUX_NIBBLES);

    // Input commands.
    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_EMIT  = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_VOLUME = 2'd0;
    localparam logic [1:0] CFG_GAP    = 2'd1;
    localparam logic [1:0] CFG_HSYNC  = 2'd2;
    localparam logic [1:0] CFG_DSYNC  = 2'd3;

    localparam logic [7:0] VOLUME_RST = 8'd254;
    localparam logic [7:0] GAP_RST    = 8'd255;
    localparam logic [7:0] GAP_NONE   = 8'd255;
    localparam logic [5:0] HSYNC_RST  = 6'd14;
    localparam logic [5:0] DSYNC_RST  = 6'd6;

    localparam logic [7:0] SYNC_BYTE   = 8'hFF;
    localparam logic [7:0] MARK_D5     = 8'hD5;
    localparam logic [7:0] MARK_AA     = 8'hAA;
    localparam logic [7:0] MARK_96     = 8'h96;
    localparam logic [7:0] MARK_AD     = 8'hAD;
    localparam logic [7:0] MARK_DE     = 8'hDE;
    localparam logic [7:0] MARK_EB     = 8'hEB;
    localparam logic [7:0] ODD_EVEN_OR = 8'hAA;

    typedef enum logic [3:0] {
        PH_HSYNC = 4'd0,
        PH_APRO  = 4'd1,
        PH_ADDR  = 4'd2,
        PH_AEPI  = 4'd3,
        PH_DSYNC = 4'd4,
        PH_DPRO  = 4'd5,
        PH_AUX   = 4'd6,
        PH_PRIM  = 4'd7,
        PH_CSUM  = 4'd8,
        PH_DEPI  = 4'd9,
        PH_GAP   = 4'd10,
        PH_END   = 4'd11
    } t_phase;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SKIP_PRE,
        S_FETCH0,
        S_FETCH1,
        S_FETCH2,
        S_FETCH3,
        S_FORM,
        S_SKIP_POST,
        S_PUT
    } t_state;

    // Which of the three store reads of an auxiliary nibble.
    typedef enum logic [1:0] {
        FT_LOW,
        FT_MID,
        FT_HIGH
    } t_fetch;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] data_index;
        logic [7:0] data_value;
        logic [7:0] cylinder;
        logic [7:0] sector_number;
        logic       use_fill;
        logic [7:0] fill_value;
    } t_in_item;

    typedef struct packed {
        logic [7:0] track_byte;
        logic       sync_zeros_after;
        logic       last_of_sector;
    } t_out_item;

    typedef struct packed {
        logic   load;
        logic   start;
        logic   fetch;
        t_fetch fetch_sel;
        logic   latch;
        t_fetch latch_sel;
        logic   form;
        logic   skip;
        logic   stop;
        logic   put;
    } t_ctrl_cmd;

    typedef struct packed {
        logic active;
        logic part_done;
        logic at_end;
        logic out_free;
    } t_ctrl_status;

    // Six-and-two disk byte table.
    function automatic logic [7:0] disk_code(input logic [5:0] nib);
        logic [7:0] b;
        case (nib)
            6'd0:  b = 8'h96;  6'd1:  b = 8'h97;  6'd2:  b = 8'h9A;  6'd3:  b = 8'h9B;
            6'd4:  b = 8'h9D;  6'd5:  b = 8'h9E;  6'd6:  b = 8'h9F;  6'd7:  b = 8'hA6;
            6'd8:  b = 8'hA7;  6'd9:  b = 8'hAB;  6'd10: b = 8'hAC;  6'd11: b = 8'hAD;
            6'd12: b = 8'hAE;  6'd13: b = 8'hAF;  6'd14: b = 8'hB2;  6'd15: b = 8'hB3;
            6'd16: b = 8'hB4;  6'd17: b = 8'hB5;  6'd18: b = 8'hB6;  6'd19: b = 8'hB7;
            6'd20: b = 8'hB9;  6'd21: b = 8'hBA;  6'd22: b = 8'hBB;  6'd23: b = 8'hBC;
            6'd24: b = 8'hBD;  6'd25: b = 8'hBE;  6'd26: b = 8'hBF;  6'd27: b = 8'hCB;
            6'd28: b = 8'hCD;  6'd29: b = 8'hCE;  6'd30: b = 8'hCF;  6'd31: b = 8'hD3;
            6'd32: b = 8'hD6;  6'd33: b = 8'hD7;  6'd34: b = 8'hD9;  6'd35: b = 8'hDA;
            6'd36: b = 8'hDB;  6'd37: b = 8'hDC;  6'd38: b = 8'hDD;  6'd39: b = 8'hDE;
            6'd40: b = 8'hDF;  6'd41: b = 8'hE5;  6'd42: b = 8'hE6;  6'd43: b = 8'hE7;
            6'd44: b = 8'hE9;  6'd45: b = 8'hEA;  6'd46: b = 8'hEB;  6'd47: b = 8'hEC;
            6'd48: b = 8'hED;  6'd49: b = 8'hEE;  6'd50: b = 8'hEF;  6'd51: b = 8'hF2;
            6'd52: b = 8'hF3;  6'd53: b = 8'hF4;  6'd54: b = 8'hF5;  6'd55: b = 8'hF6;
            6'd56: b = 8'hF7;  6'd57: b = 8'hF9;  6'd58: b = 8'hFA;  6'd59: b = 8'hFB;
            6'd60: b = 8'hFC;  6'd61: b = 8'hFD;  6'd62: b = 8'hFE;  6'd63: b = 8'hFF;
            default: b = 8'hFF;
        endcase
        return b;
    endfunction

endpackage

// File: design/gcr_ram.sv
// ----------------------------------------------------------------------------
// gcr_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gcr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/gcr_ctrl.sv
// ----------------------------------------------------------------------------
// gcr_ctrl
// Controller: sequences accept, part skipping, store reads, byte forming and
// the hand-off of each result to the output register.
// ----------------------------------------------------------------------------
module gcr_ctrl
    import gcr_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    input  logic [1:0]   i_command,
    output logic         o_in_ready,
    input  t_ctrl_status i_status,
    output t_ctrl_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    assign w_accept = i_in_valid && (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept && (i_command == CMD_EMIT) && i_status.active) begin
                    n_state = S_SKIP_PRE;
                end
            end
            S_SKIP_PRE: begin
                if (i_status.at_end) begin
                    n_state = S_IDLE;
                end else if (!i_status.part_done) begin
                    n_state = S_FETCH0;
                end
            end
            S_FETCH0:  n_state = S_FETCH1;
            S_FETCH1:  n_state = S_FETCH2;
            S_FETCH2:  n_state = S_FETCH3;
            S_FETCH3:  n_state = S_FORM;
            S_FORM:    n_state = S_SKIP_POST;
            S_SKIP_POST: begin
                if (i_status.at_end || !i_status.part_done) begin
                    n_state = S_PUT;
                end
            end
            S_PUT: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.fetch_sel = FT_LOW;
        o_cmd.latch_sel = FT_LOW;
        o_in_ready      = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.load  = w_accept && (i_command == CMD_LOAD);
                o_cmd.start = w_accept && (i_command == CMD_START);
            end
            S_SKIP_PRE: begin
                o_cmd.stop = i_status.at_end;
                o_cmd.skip = !i_status.at_end && i_status.part_done;
            end
            S_FETCH0: begin
                o_cmd.fetch     = 1'b1;
                o_cmd.fetch_sel = FT_LOW;
            end
            S_FETCH1: begin
                o_cmd.latch     = 1'b1;
                o_cmd.latch_sel = FT_LOW;
                o_cmd.fetch     = 1'b1;
                o_cmd.fetch_sel = FT_MID;
            end
            S_FETCH2: begin
                o_cmd.latch     = 1'b1;
                o_cmd.latch_sel = FT_MID;
                o_cmd.fetch     = 1'b1;
                o_cmd.fetch_sel = FT_HIGH;
            end
            S_FETCH3: begin
                o_cmd.latch     = 1'b1;
                o_cmd.latch_sel = FT_HIGH;
            end
            S_FORM: begin
                o_cmd.form = 1'b1;
            end
            S_SKIP_POST: begin
                o_cmd.skip = !i_status.at_end && i_status.part_done;
            end
            S_PUT: begin
                o_cmd.put = i_status.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

// File: design/gcr_datapath.sv
// ----------------------------------------------------------------------------
// gcr_datapath
// Datapath: configuration registers, sector store, field position, nibble
// chain, byte forming and the output register.
// ----------------------------------------------------------------------------
module gcr_datapath
    import gcr_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_ctrl_cmd    i_cmd,
    output t_ctrl_status o_status,
    input  t_in_item     i_in_data,
    input  logic         i_cfg_valid,
    input  logic [1:0]   i_cfg_index,
    input  logic [7:0]   i_cfg_data,
    output logic         o_out_valid,
    input  logic         i_out_ready,
    output t_out_item    o_out_data
);

    logic [7:0]       r_volume, n_volume;
    logic [7:0]       r_gap, n_gap;
    logic [5:0]       r_hsync, n_hsync;
    logic [5:0]       r_dsync, n_dsync;
    logic             r_active, n_active;
    t_phase           r_phase, n_phase;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [5:0]       r_chain, n_chain;
    logic [7:0]       r_cyl, n_cyl;
    logic [7:0]       r_sec, n_sec;
    logic [8:0]       r_fill, n_fill;
    logic             r_oor, n_oor;
    logic [7:0]       r_d0, n_d0;
    logic [1:0]       r_d1, n_d1;
    logic [1:0]       r_d2, n_d2;
    logic [7:0]       r_byte, n_byte;
    logic             r_sync, n_sync;
    logic             r_out_valid, n_out_valid;
    t_out_item        r_out, n_out;

    logic [POS_W-1:0] w_len;
    logic [POS_W-1:0] w_raddr;
    logic [7:0]       w_rdata;
    logic [7:0]       w_data;
    logic [5:0]       w_nib;
    logic [7:0]       w_addr_v;
    logic [7:0]       w_addr_byte;
    logic [7:0]       w_form_byte;
    logic             w_at_end;
    logic             w_out_free;

    gcr_ram #(
        .WIDTH (8),
        .DEPTH (SECTOR_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load),
        .i_waddr (i_in_data.data_index[STORE_AW-1:0]),
        .i_wdata (i_in_data.data_value),
        .i_raddr (w_raddr[STORE_AW-1:0]),
        .o_rdata (w_rdata)
    );

    // Length of the current part; counts are read live.
    always_comb begin
        case (r_phase)
            PH_HSYNC: w_len = POS_W'(r_hsync);
            PH_APRO, PH_AEPI, PH_DPRO, PH_DEPI: w_len = POS_W'(3);
            PH_ADDR:  w_len = POS_W'(8);
            PH_DSYNC: w_len = POS_W'(r_dsync);
            PH_AUX:   w_len = POS_W'(AUX_NIBBLES);
            PH_PRIM:  w_len = POS_W'(SECTOR_BYTES);
            PH_CSUM:  w_len = POS_W'(1);
            PH_GAP:   w_len = (r_gap == GAP_NONE) ? '0 : POS_W'(r_gap);
            default:  w_len = '0;
        endcase
    end

    assign w_at_end   = (r_phase == PH_END);
    assign w_out_free = !r_out_valid || i_out_ready;

    assign o_status.active    = r_active;
    assign o_status.part_done = (r_pos >= w_len);
    assign o_status.at_end    = w_at_end;
    assign o_status.out_free  = w_out_free;

    always_comb begin
        case (i_cmd.fetch_sel)
            FT_MID:  w_raddr = r_pos + AUX_OFS1;
            FT_HIGH: w_raddr = r_pos + AUX_OFS2;
            default: w_raddr = r_pos;
        endcase
    end

    // Positions past the sector end read as zero, also in fill mode.
    always_comb begin
        if (r_oor) begin
            w_data = '0;
        end else if (r_fill[8]) begin
            w_data = r_fill[7:0];
        end else begin
            w_data = w_rdata;
        end
    end

    always_comb begin
        case (r_pos[2:1])
            2'd0:    w_addr_v = r_volume;
            2'd1:    w_addr_v = r_cyl;
            2'd2:    w_addr_v = r_sec;
            default: w_addr_v = r_volume ^ r_cyl ^ r_sec;
        endcase
        w_addr_byte = r_pos[0] ? (w_addr_v | ODD_EVEN_OR) : ((w_addr_v >> 1) | ODD_EVEN_OR);
    end

    // Low two bits of three bytes, each pair swapped, in the auxiliary part; else bits 7:2 of the first byte.
    always_comb begin
        if (r_phase == PH_AUX) begin
            w_nib = {r_d2[0], r_d2[1], r_d1[0], r_d1[1], r_d0[0], r_d0[1]};
        end else begin
            w_nib = r_d0[7:2];
        end
    end

    always_comb begin
        case (r_phase)
            PH_APRO: begin
                case (r_pos[1:0])
                    2'd0:    w_form_byte = MARK_D5;
                    2'd1:    w_form_byte = MARK_AA;
                    default: w_form_byte = MARK_96;
                endcase
            end
            PH_ADDR: w_form_byte = w_addr_byte;
            PH_AEPI, PH_DEPI: begin
                case (r_pos[1:0])
                    2'd0:    w_form_byte = MARK_DE;
                    2'd1:    w_form_byte = MARK_AA;
                    default: w_form_byte = MARK_EB;
                endcase
            end
            PH_DPRO: begin
                case (r_pos[1:0])
                    2'd0:    w_form_byte = MARK_D5;
                    2'd1:    w_form_byte = MARK_AA;
                    default: w_form_byte = MARK_AD;
                endcase
            end
            PH_AUX, PH_PRIM: w_form_byte = disk_code(w_nib ^ r_chain);
            PH_CSUM: w_form_byte = disk_code(r_chain);
            default: w_form_byte = SYNC_BYTE;
        endcase
    end

    always_comb begin
        n_volume    = r_volume;
        n_gap       = r_gap;
        n_hsync     = r_hsync;
        n_dsync     = r_dsync;
        n_active    = r_active;
        n_phase     = r_phase;
        n_pos       = r_pos;
        n_chain     = r_chain;
        n_cyl       = r_cyl;
        n_sec       = r_sec;
        n_fill      = r_fill;
        n_oor       = r_oor;
        n_d0        = r_d0;
        n_d1        = r_d1;
        n_d2        = r_d2;
        n_byte      = r_byte;
        n_sync      = r_sync;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_VOLUME: n_volume = i_cfg_data;
                CFG_GAP:    n_gap    = i_cfg_data;
                CFG_HSYNC:  n_hsync  = i_cfg_data[5:0];
                CFG_DSYNC:  n_dsync  = i_cfg_data[5:0];
                default:    n_volume = r_volume;
            endcase
        end

        if (i_cmd.start) begin
            n_cyl    = i_in_data.cylinder;
            n_sec    = i_in_data.sector_number;
            n_fill   = i_in_data.use_fill ? {1'b1, i_in_data.fill_value} : '0;
            n_active = 1'b1;
            n_phase  = PH_HSYNC;
            n_pos    = '0;
            n_chain  = '0;
        end

        if (i_cmd.skip) begin
            n_phase = t_phase'(r_phase + 4'd1);
            n_pos   = '0;
        end

        if (i_cmd.stop) begin
            n_active = 1'b0;
        end

        if (i_cmd.fetch) begin
            n_oor = w_raddr[POS_W-1];
        end

        if (i_cmd.latch) begin
            case (i_cmd.latch_sel)
                FT_MID:  n_d1 = w_data[1:0];
                FT_HIGH: n_d2 = w_data[1:0];
                default: n_d0 = w_data;
            endcase
        end

        if (i_cmd.form) begin
            n_byte = w_form_byte;
            n_sync = (r_phase == PH_HSYNC) || (r_phase == PH_DSYNC);
            n_pos  = r_pos + POS_W'(1);
            if ((r_phase == PH_AUX) || (r_phase == PH_PRIM)) begin
                n_chain = w_nib;
            end
        end

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        if (i_cmd.put) begin
            n_out.track_byte       = r_byte;
            n_out.sync_zeros_after = r_sync;
            n_out.last_of_sector   = w_at_end;
            n_out_valid            = 1'b1;
            if (w_at_end) begin
                n_active = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_volume    <= VOLUME_RST;
            r_gap       <= GAP_RST;
            r_hsync     <= HSYNC_RST;
            r_dsync     <= DSYNC_RST;
            r_active    <= 1'b0;
            r_phase     <= PH_HSYNC;
            r_pos       <= '0;
            r_chain     <= '0;
            r_cyl       <= '0;
            r_sec       <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_volume    <= n_volume;
            r_gap       <= n_gap;
            r_hsync     <= n_hsync;
            r_dsync     <= n_dsync;
            r_active    <= n_active;
            r_phase     <= n_phase;
            r_pos       <= n_pos;
            r_chain     <= n_chain;
            r_cyl       <= n_cyl;
            r_sec       <= n_sec;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_oor  <= n_oor;
        r_d0   <= n_d0;
        r_d1   <= n_d1;
        r_d2   <= n_d2;
        r_byte <= n_byte;
        r_sync <= n_sync;
        r_out  <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// File: design/gcr_6and2_sector_encoder_core.sv
// ----------------------------------------------------------------------------
// gcr_6and2_sector_encoder_core
// Six-and-two GCR sector encoder: turns a loaded or filled sector into its
// stream of disk bytes, one byte per emit command.
// ----------------------------------------------------------------------------
// Load and start commands are taken in the idle state; the next beat is taken
// in the following cycle. An emit steps through skipping of empty parts, three
// reads through the sector store's one read port, forming of the byte, skipping
// of finished parts and the hand-off, which waits for a free output register.
// The next beat is taken the cycle after the result is registered, so no emit
// is taken while one is in progress. Results sit in an output register, so the
// next beat is accepted while one waits. Synchronous active-low reset restores
// the register defaults and ends any sector; the sector store is not cleared.
module gcr_6and2_sector_encoder_core
    import gcr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in_item   i_in_data,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out_item  o_out_data,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    t_ctrl_cmd    w_cmd;
    t_ctrl_status w_status;
    logic         w_in_accept;

    assign o_cfg_ready = 1'b1;
    assign w_in_accept = i_in_valid && o_in_ready;

    gcr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_command  (i_in_data.command),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    gcr_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // An emit while no sector is active produces no result.
    a_idle_emit_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_accept && (i_in_data.command == CMD_EMIT) && !w_status.active)
            |=> !$rose(o_out_valid))
        else $error("result produced for an emit with no active sector");

    // A start always leaves a sector active.
    a_start_activates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_accept && (i_in_data.command == CMD_START)) |=> w_status.active)
        else $error("start did not activate a sector");

    // Self-sync beats are always 0xFF.
    a_sync_is_ff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.sync_zeros_after) |-> (o_out_data.track_byte == SYNC_BYTE))
        else $error("self-sync flag on a byte other than 0xFF");

    // A sync byte is always followed by a prolog, so it can never end a sector.
    a_sync_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.sync_zeros_after && o_out_data.last_of_sector))
        else $error("self-sync byte flagged as last of sector");

endmodule
